[hw/rtl/avs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// avs_pkg: shared types and constants of the aim vector angle and speed block
// Item structs, the axis codes that bypass the CORDIC, the phase format and
// the arctangent table of the rotation stages.
// ----------------------------------------------------------------------------
package avs_pkg;

	localparam int FIELD_W       = 12;
	localparam int ANGLE_W       = 17;
	localparam int SPEED_W       = 8;
	localparam int SPEED_CMP_W   = 17;

	// Phase accumulator: degrees with 16 fraction bits.
	localparam int Z_FRAC        = 16;
	localparam int Z_W           = 27;
	localparam int ATAN_LEN      = 24;

	localparam int DEF_COORD_BITS      = 12;
	localparam int DEF_ANGLE_FRAC_BITS = 8;
	localparam int DEF_CORDIC_STAGES   = 16;
	localparam int DEF_SPEED_LIMIT     = 160;

	localparam logic REG_AIM_X = 1'b0;
	localparam logic REG_AIM_Y = 1'b1;

	localparam logic signed [Z_W-1:0] Z_90  = Z_W'(90) <<< Z_FRAC;
	localparam logic signed [Z_W-1:0] Z_180 = Z_W'(180) <<< Z_FRAC;

	typedef struct packed {
		logic [FIELD_W-1:0] pointer_x;
		logic [FIELD_W-1:0] pointer_y;
	} in_item_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle_deg;
		logic [SPEED_W-1:0]        speed;
	} out_item_t;

	// Vectors that lie on an axis get an exact angle instead of the CORDIC phase.
	typedef enum logic [2:0] {
		AXIS_NONE,
		AXIS_ZERO,
		AXIS_HALF_TURN,
		AXIS_PLUS_90,
		AXIS_MINUS_90
	} axis_t;

	typedef struct packed {
		logic  valid;
		axis_t axis;
	} stage_ctl_t;

	// atan(2^-i) in degrees, 16 fraction bits, rounded to nearest.
	function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			0:  v = Z_W'(2949120);
			1:  v = Z_W'(1740967);
			2:  v = Z_W'(919879);
			3:  v = Z_W'(466945);
			4:  v = Z_W'(234379);
			5:  v = Z_W'(117304);
			6:  v = Z_W'(58666);
			7:  v = Z_W'(29335);
			8:  v = Z_W'(14668);
			9:  v = Z_W'(7334);
			10: v = Z_W'(3667);
			11: v = Z_W'(1833);
			12: v = Z_W'(917);
			13: v = Z_W'(458);
			14: v = Z_W'(229);
			15: v = Z_W'(115);
			16: v = Z_W'(57);
			17: v = Z_W'(29);
			18: v = Z_W'(14);
			19: v = Z_W'(7);
			20: v = Z_W'(4);
			21: v = Z_W'(2);
			22: v = Z_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/avs_prep.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// avs_prep: vector forming and CORDIC setup
// Two stages: the difference to the aim point, then the squared length, the
// axis classification and the half-plane fold of the rotation start values.
// ----------------------------------------------------------------------------
module avs_prep #(
	parameter int COORD_BITS = avs_pkg::DEF_COORD_BITS
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 accept,
	input  avs_pkg::in_item_t                   item,
	input  wire [COORD_BITS-1:0]                aim_x,
	input  wire [COORD_BITS-1:0]                aim_y,
	output avs_pkg::stage_ctl_t                 ctl_out,
	output logic signed [COORD_BITS+avs_pkg::Z_FRAC+2:0] x_out,
	output logic signed [COORD_BITS+avs_pkg::Z_FRAC+2:0] y_out,
	output logic signed [avs_pkg::Z_W-1:0]      z_out,
	output logic [2*COORD_BITS+1:0]             n_out
);
	import avs_pkg::*;

	localparam int XY_W = COORD_BITS + Z_FRAC + 3;
	localparam int D_W  = COORD_BITS + 1;
	localparam int N_W  = 2 * COORD_BITS + 2;

	logic [COORD_BITS-1:0]  px;
	logic [COORD_BITS-1:0]  py;
	logic                   valid_s1;
	logic signed [D_W-1:0]  dx_s1;
	logic signed [D_W-1:0]  dy_s1;

	logic signed [N_W-1:0]  dx2;
	logic signed [N_W-1:0]  dy2;
	logic [N_W-1:0]         sq;
	axis_t                  axis;
	logic signed [XY_W-1:0] x_init;
	logic signed [XY_W-1:0] y_init;
	logic signed [Z_W-1:0]  z_init;

	stage_ctl_t             ctl_s2;
	logic signed [XY_W-1:0] x_s2;
	logic signed [XY_W-1:0] y_s2;
	logic signed [Z_W-1:0]  z_s2;
	logic [N_W-1:0]         n_s2;

	assign px = COORD_BITS'(item.pointer_x);
	assign py = COORD_BITS'(item.pointer_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= signed'({1'b0, aim_x}) - signed'({1'b0, px});
		dy_s1 <= signed'({1'b0, py}) - signed'({1'b0, aim_y});
	end

	always_comb begin
		dx2 = N_W'(dx_s1) * N_W'(dx_s1);
		dy2 = N_W'(dy_s1) * N_W'(dy_s1);
		sq  = $unsigned(dx2) + $unsigned(dy2);

		if (dx_s1 == '0 && dy_s1 == '0) begin
			axis = AXIS_ZERO;
		end else if (dx_s1 == '0) begin
			axis = dy_s1[D_W-1] ? AXIS_HALF_TURN : AXIS_ZERO;
		end else if (dy_s1 == '0) begin
			axis = dx_s1[D_W-1] ? AXIS_MINUS_90 : AXIS_PLUS_90;
		end else begin
			axis = AXIS_NONE;
		end

		// The left half-plane is folded onto the right one; the phase starts at
		// a half turn whose sign follows dx.
		x_init = XY_W'(dy_s1) <<< Z_FRAC;
		y_init = XY_W'(dx_s1) <<< Z_FRAC;
		z_init = '0;
		if (dy_s1[D_W-1]) begin
			x_init = -x_init;
			y_init = -y_init;
			z_init = dx_s1[D_W-1] ? -Z_180 : Z_180;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '{valid: 1'b0, axis: AXIS_NONE};
		end else begin
			ctl_s2 <= '{valid: valid_s1, axis: axis};
		end
	end

	always_ff @(posedge clk) begin
		x_s2 <= x_init;
		y_s2 <= y_init;
		z_s2 <= z_init;
		n_s2 <= sq;
	end

	assign ctl_out = ctl_s2;
	assign x_out   = x_s2;
	assign y_out   = y_s2;
	assign z_out   = z_s2;
	assign n_out   = n_s2;

endmodule
`default_nettype wire

[hw/rtl/avs_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// avs_stage: one stage of the rotation and square root chain
// One CORDIC vectoring rotation and one bit of the digit-by-digit integer
// square root, each only where the stage index lies within its length.
// ----------------------------------------------------------------------------
module avs_stage #(
	parameter int COORD_BITS    = avs_pkg::DEF_COORD_BITS,
	parameter int CORDIC_STAGES = avs_pkg::DEF_CORDIC_STAGES,
	parameter int STAGE         = 0
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  avs_pkg::stage_ctl_t                 ctl_in,
	input  wire signed [COORD_BITS+avs_pkg::Z_FRAC+2:0] x_in,
	input  wire signed [COORD_BITS+avs_pkg::Z_FRAC+2:0] y_in,
	input  wire signed [avs_pkg::Z_W-1:0]       z_in,
	input  wire [2*COORD_BITS+1:0]              n_in,
	input  wire [COORD_BITS+2:0]                rem_in,
	input  wire [COORD_BITS:0]                  root_in,
	output avs_pkg::stage_ctl_t                 ctl_out,
	output logic signed [COORD_BITS+avs_pkg::Z_FRAC+2:0] x_out,
	output logic signed [COORD_BITS+avs_pkg::Z_FRAC+2:0] y_out,
	output logic signed [avs_pkg::Z_W-1:0]      z_out,
	output logic [2*COORD_BITS+1:0]             n_out,
	output logic [COORD_BITS+2:0]               rem_out,
	output logic [COORD_BITS:0]                 root_out
);
	import avs_pkg::*;

	localparam int XY_W      = COORD_BITS + Z_FRAC + 3;
	localparam int ROOT_BITS = COORD_BITS + 1;
	localparam int N_W       = 2 * ROOT_BITS;
	localparam int REM_W     = ROOT_BITS + 2;
	localparam bit DO_ROT    = (STAGE < CORDIC_STAGES) && (STAGE < ATAN_LEN);
	localparam bit DO_ROOT   = (STAGE < ROOT_BITS);
	localparam logic signed [Z_W-1:0] ATAN = atan_q16(STAGE);

	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [XY_W-1:0] x_nxt;
	logic signed [XY_W-1:0] y_nxt;
	logic signed [Z_W-1:0]  z_nxt;
	logic [REM_W-1:0]       rem_sh;
	logic [REM_W-1:0]       trial;
	logic                   fits;
	logic [REM_W-1:0]       rem_nxt;
	logic [ROOT_BITS-1:0]   root_nxt;
	logic [N_W-1:0]         n_nxt;

	stage_ctl_t             ctl_s1;
	logic signed [XY_W-1:0] x_s1;
	logic signed [XY_W-1:0] y_s1;
	logic signed [Z_W-1:0]  z_s1;
	logic [N_W-1:0]         n_s1;
	logic [REM_W-1:0]       rem_s1;
	logic [ROOT_BITS-1:0]   root_s1;

	always_comb begin
		xs = x_in >>> STAGE;
		ys = y_in >>> STAGE;
		x_nxt = x_in;
		y_nxt = y_in;
		z_nxt = z_in;
		if (DO_ROT) begin
			if (!y_in[XY_W-1]) begin
				x_nxt = x_in + ys;
				y_nxt = y_in - xs;
				z_nxt = z_in + ATAN;
			end else begin
				x_nxt = x_in - ys;
				y_nxt = y_in + xs;
				z_nxt = z_in - ATAN;
			end
		end
	end

	// Two radicand bits enter the remainder per stage, most significant first.
	always_comb begin
		rem_sh   = {rem_in[REM_W-3:0], n_in[N_W-1 -: 2]};
		trial    = {root_in, 2'b01};
		fits     = (rem_sh >= trial);
		rem_nxt  = rem_in;
		root_nxt = root_in;
		n_nxt    = n_in;
		if (DO_ROOT) begin
			rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
			root_nxt = {root_in[ROOT_BITS-2:0], fits};
			n_nxt    = n_in << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{valid: 1'b0, axis: AXIS_NONE};
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_nxt;
		y_s1    <= y_nxt;
		z_s1    <= z_nxt;
		n_s1    <= n_nxt;
		rem_s1  <= rem_nxt;
		root_s1 <= root_nxt;
	end

	assign ctl_out  = ctl_s1;
	assign x_out    = x_s1;
	assign y_out    = y_s1;
	assign z_out    = z_s1;
	assign n_out    = n_s1;
	assign rem_out  = rem_s1;
	assign root_out = root_s1;

endmodule
`default_nettype wire

[hw/rtl/avs_finish.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// avs_finish: result formatting
// Picks the exact axis angle or the CORDIC phase, rounds it to the output
// fraction width, clamps it to a half turn and saturates the speed.
// ----------------------------------------------------------------------------
module avs_finish #(
	parameter int COORD_BITS      = avs_pkg::DEF_COORD_BITS,
	parameter int ANGLE_FRAC_BITS = avs_pkg::DEF_ANGLE_FRAC_BITS,
	parameter int SPEED_LIMIT     = avs_pkg::DEF_SPEED_LIMIT
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  avs_pkg::stage_ctl_t           ctl_in,
	input  wire signed [avs_pkg::Z_W-1:0] z_in,
	input  wire [COORD_BITS:0]            root_in,
	output logic                          done,
	output avs_pkg::out_item_t            result
);
	import avs_pkg::*;

	localparam int ROOT_BITS  = COORD_BITS + 1;
	localparam int RND_SHIFT  = Z_FRAC - ANGLE_FRAC_BITS;
	localparam logic signed [Z_W-1:0] HALF = (Z_W'(1) <<< RND_SHIFT) >>> 1;
	localparam logic signed [Z_W-1:0] LIM  = Z_W'(180) <<< ANGLE_FRAC_BITS;
	localparam logic [SPEED_CMP_W-1:0] LIMIT = SPEED_CMP_W'(SPEED_LIMIT);

	logic signed [Z_W-1:0]   z_sel;
	logic signed [Z_W-1:0]   z_rnd;
	logic signed [Z_W-1:0]   z_clamp;
	logic [SPEED_CMP_W-1:0]  half_len;
	logic [SPEED_CMP_W-1:0]  spd;

	logic                    done_s1;
	out_item_t               result_s1;

	always_comb begin
		case (ctl_in.axis)
			AXIS_NONE:      z_sel = z_in;
			AXIS_ZERO:      z_sel = '0;
			AXIS_HALF_TURN: z_sel = Z_180;
			AXIS_PLUS_90:   z_sel = Z_90;
			AXIS_MINUS_90:  z_sel = -Z_90;
			default:        z_sel = '0;
		endcase

		// Arithmetic shift floors, so adding half rounds ties upward.
		z_rnd = (z_sel + HALF) >>> RND_SHIFT;
		if (z_rnd > LIM) begin
			z_clamp = LIM;
		end else if (z_rnd < -LIM) begin
			z_clamp = -LIM;
		end else begin
			z_clamp = z_rnd;
		end

		half_len = SPEED_CMP_W'(root_in >> 1);
		spd = (half_len > LIMIT) ? LIMIT : half_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_s1.angle_deg <= ANGLE_W'(z_clamp);
		result_s1.speed     <= SPEED_W'(spd);
	end

	assign done   = done_s1;
	assign result = result_s1;

	initial_unused_check: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 |-> $past(ctl_in.valid))
		else $error("result strobe without an item in the last chain stage");

	axis_angle_check: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_in.valid && ctl_in.axis == AXIS_ZERO) |=> (result_s1.angle_deg == '0))
		else $error("vector on the positive axis did not give angle zero");

	speed_zero_check: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_in.valid && root_in == '0) |=> (result_s1.speed == '0))
		else $error("zero length did not give speed zero");

endmodule
`default_nettype wire

[hw/rtl/aim_vector_angle_and_speed_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aim_vector_angle_and_speed_top: pointer angle and speed against an aim point
// Angle atan2(aim_x - pointer_x, pointer_y - aim_y) in degrees and half the
// vector length, with the aim point held in two APB registers.
// ----------------------------------------------------------------------------
// One item is accepted in every cycle; busy stays low. Each result appears on
// result with done high for one cycle, and must be taken in that cycle since
// the block cannot hold it. Items pass through two stages that form the vector
// and its squared length, then the stage chain, in which each stage performs
// one CORDIC rotation and one bit of the square root where its index lies
// within their lengths, and one stage that rounds and saturates. Write aim_x
// at byte address 0 and aim_y at address 4 only while no items are in flight.
module aim_vector_angle_and_speed_top #(
	parameter int COORD_BITS      = avs_pkg::DEF_COORD_BITS,
	parameter int ANGLE_FRAC_BITS = avs_pkg::DEF_ANGLE_FRAC_BITS,
	parameter int CORDIC_STAGES   = avs_pkg::DEF_CORDIC_STAGES,
	parameter int SPEED_LIMIT     = avs_pkg::DEF_SPEED_LIMIT
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  avs_pkg::in_item_t   sample,
	output logic                done,
	output avs_pkg::out_item_t  result,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire [2:0]           paddr,
	input  wire [31:0]          pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import avs_pkg::*;

	localparam int XY_W      = COORD_BITS + Z_FRAC + 3;
	localparam int ROOT_BITS = COORD_BITS + 1;
	localparam int N_W       = 2 * ROOT_BITS;
	localparam int REM_W     = ROOT_BITS + 2;
	localparam int DEPTH     = (CORDIC_STAGES > ROOT_BITS) ? CORDIC_STAGES : ROOT_BITS;
	localparam int LATENCY   = DEPTH + 3;

	logic [COORD_BITS-1:0]  aim_x_q;
	logic [COORD_BITS-1:0]  aim_y_q;
	logic                   cfg_wr;
	logic                   accept;

	stage_ctl_t             ctl_c  [0:DEPTH];
	logic signed [XY_W-1:0] x_c    [0:DEPTH];
	logic signed [XY_W-1:0] y_c    [0:DEPTH];
	logic signed [Z_W-1:0]  z_c    [0:DEPTH];
	logic [N_W-1:0]         n_c    [0:DEPTH];
	logic [REM_W-1:0]       rem_c  [0:DEPTH];
	logic [ROOT_BITS-1:0]   root_c [0:DEPTH];

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aim_x_q <= '0;
			aim_y_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_AIM_X) begin
				aim_x_q <= COORD_BITS'(pwdata);
			end else begin
				aim_y_q <= COORD_BITS'(pwdata);
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_AIM_X) begin
			prdata = 32'(aim_x_q);
		end else begin
			prdata = 32'(aim_y_q);
		end
	end

	avs_prep #(
		.COORD_BITS(COORD_BITS)
	) u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (sample),
		.aim_x   (aim_x_q),
		.aim_y   (aim_y_q),
		.ctl_out (ctl_c[0]),
		.x_out   (x_c[0]),
		.y_out   (y_c[0]),
		.z_out   (z_c[0]),
		.n_out   (n_c[0])
	);

	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar k = 0; k < DEPTH; k++) begin : g_stage
		avs_stage #(
			.COORD_BITS    (COORD_BITS),
			.CORDIC_STAGES (CORDIC_STAGES),
			.STAGE         (k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (ctl_c[k]),
			.x_in     (x_c[k]),
			.y_in     (y_c[k]),
			.z_in     (z_c[k]),
			.n_in     (n_c[k]),
			.rem_in   (rem_c[k]),
			.root_in  (root_c[k]),
			.ctl_out  (ctl_c[k+1]),
			.x_out    (x_c[k+1]),
			.y_out    (y_c[k+1]),
			.z_out    (z_c[k+1]),
			.n_out    (n_c[k+1]),
			.rem_out  (rem_c[k+1]),
			.root_out (root_c[k+1])
		);
	end

	avs_finish #(
		.COORD_BITS      (COORD_BITS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.SPEED_LIMIT     (SPEED_LIMIT)
	) u_finish (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_c[DEPTH]),
		.z_in    (z_c[DEPTH]),
		.root_in (root_c[DEPTH]),
		.done    (done),
		.result  (result)
	);

	latency_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("accepted item did not produce a result at the fixed latency");

	aim_x_write_check: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && paddr[2] == REG_AIM_X) |=> (aim_x_q == $past(COORD_BITS'(pwdata))))
		else $error("aim_x register did not take the written value");

	aim_y_write_check: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && paddr[2] == REG_AIM_Y) |=> (aim_y_q == $past(COORD_BITS'(pwdata))))
		else $error("aim_y register did not take the written value");

endmodule
`default_nettype wire

[sim/aim_vector_angle_and_speed_top_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aim_vector_angle_and_speed_top_test: self-checking bench for the aim block
// Feeds pointer positions against aim points set over APB. Each result is
// compared with a typed answer or an in-bench CORDIC and square-root model.
// ----------------------------------------------------------------------------
module aim_vector_angle_and_speed_top_test;
	import avs_pkg::*;

	localparam int PIPE_LATENCY  = 19;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_ITEMS   = 182;
	localparam int CORDIC_ROUNDS = 16;
	localparam longint PHASE_ONE = 64'sd65536;

	typedef struct packed {
		logic [11:0]        ax;
		logic [11:0]        ay;
		logic [11:0]        px;
		logic [11:0]        py;
		logic               known;
		logic signed [16:0] angle;
		logic [7:0]         speed;
	} aim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	in_item_t    sample = '0;
	logic        done;
	out_item_t   result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Typed answer that rides along with a directed item.
	logic        pinned_known = 1'b0;
	out_item_t   pinned_answer = '0;

	out_item_t   awaited_readings[$];
	int          mismatches = 0;
	int          burst_left = 0;
	logic [11:0] aim_x_seen = '0;
	logic [11:0] aim_y_seen = '0;
	logic [11:0] aim_x_set = '0;
	logic [11:0] aim_y_set = '0;

	longint atan_step_q16 [CORDIC_ROUNDS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	aim_row_t drill [23] = '{
		'{12'd0,    12'd0,    12'd0,    12'd0,    1'b1, 17'sd0,      8'd0},
		'{12'd0,    12'd0,    12'd0,    12'd4095, 1'b1, 17'sd0,      8'd160},
		'{12'd0,    12'd0,    12'd4095, 12'd0,    1'b1, -17'sd23040, 8'd160},
		'{12'd0,    12'd0,    12'd4095, 12'd4095, 1'b0, 17'sd0,      8'd0},
		'{12'd0,    12'd0,    12'd1,    12'd1,    1'b0, 17'sd0,      8'd0},
		'{12'd4095, 12'd4095, 12'd0,    12'd0,    1'b0, 17'sd0,      8'd0},
		'{12'd4095, 12'd4095, 12'd4095, 12'd0,    1'b1, 17'sd46080,  8'd160},
		'{12'd4095, 12'd4095, 12'd0,    12'd4095, 1'b1, 17'sd23040,  8'd160},
		'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 17'sd0,      8'd0},
		'{12'd2048, 12'd2048, 12'd2048, 12'd2368, 1'b1, 17'sd0,      8'd160},
		'{12'd2048, 12'd2048, 12'd2048, 12'd2369, 1'b1, 17'sd0,      8'd160},
		'{12'd2048, 12'd2048, 12'd2048, 12'd2370, 1'b1, 17'sd0,      8'd160},
		'{12'd2048, 12'd2048, 12'd2048, 12'd2367, 1'b1, 17'sd0,      8'd159},
		'{12'd2048, 12'd2048, 12'd2051, 12'd2052, 1'b0, 17'sd0,      8'd0},
		'{12'd2048, 12'd2048, 12'd2047, 12'd2047, 1'b0, 17'sd0,      8'd0},
		'{12'd2048, 12'd2048, 12'd2049, 12'd2047, 1'b0, 17'sd0,      8'd0},
		'{12'd2048, 12'd2048, 12'd2047, 12'd0,    1'b0, 17'sd0,      8'd0},
		'{12'd2048, 12'd2048, 12'd2049, 12'd0,    1'b0, 17'sd0,      8'd0},
		'{12'd2048, 12'd2048, 12'd0,    12'd2048, 1'b1, 17'sd23040,  8'd160},
		'{12'd2048, 12'd2048, 12'd4095, 12'd2048, 1'b1, -17'sd23040, 8'd160},
		'{12'd2048, 12'd2048, 12'd2048, 12'd0,    1'b1, 17'sd46080,  8'd160},
		'{12'd2048, 12'd2048, 12'd2048, 12'd2049, 1'b1, 17'sd0,      8'd0},
		'{12'd2048, 12'd2048, 12'd2048, 12'd2050, 1'b1, 17'sd0,      8'd1}
	};

	aim_vector_angle_and_speed_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.sample  (sample),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("aim_vector_angle_and_speed_top verification failed");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Angle of (dx, dy) by vectoring CORDIC in Q16 degrees, and the speed as half
	// the exact integer square root of the squared length, capped at 160.
	function automatic out_item_t predict_aim_reading(input logic [11:0] ax,
			input logic [11:0] ay, input logic [11:0] px, input logic [11:0] py);
		longint dx, dy, x, y, z, xs, ys, r, sq, root, bitv;
		int i;
		out_item_t res;
		dx = longint'(ax) - longint'(px);
		dy = longint'(py) - longint'(ay);
		sq = dx * dx + dy * dy;
		root = 0;
		bitv = 64'sd1 << 30;
		while (bitv > sq)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (sq >= root + bitv) begin
				sq = sq - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		root = root >> 1;
		if (root > 160)
			root = 160;
		if (dx == 0 && dy == 0) begin
			z = 0;
		end else if (dx == 0) begin
			z = (dy > 0) ? 0 : 180 * PHASE_ONE;
		end else if (dy == 0) begin
			z = (dx > 0) ? 90 * PHASE_ONE : -90 * PHASE_ONE;
		end else begin
			x = dy * PHASE_ONE;
			y = dx * PHASE_ONE;
			z = 0;
			// Left half-plane: rotate by a half turn before the iterations.
			if (x < 0) begin
				z = (y >= 0) ? 180 * PHASE_ONE : -180 * PHASE_ONE;
				x = -x;
				y = -y;
			end
			for (i = 0; i < CORDIC_ROUNDS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + atan_step_q16[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - atan_step_q16[i];
				end
			end
		end
		r = (z + 128) >>> 8;
		if (r > 46080)
			r = 46080;
		if (r < -46080)
			r = -46080;
		res.angle_deg = r[16:0];
		res.speed = root[7:0];
		return res;
	endfunction

	function automatic int draw_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			burst_left = $urandom_range(20, 60);
		return $urandom_range(0, 5);
	endfunction

	function automatic logic [11:0] clip_coord(input int v);
		if (v < 0)
			return 12'd0;
		if (v > 4095)
			return 12'd4095;
		return v[11:0];
	endfunction

	task automatic apb_access(input logic wr, input logic idx, input logic [31:0] data,
			output logic [31:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Upper data bits carry noise, since only the low coordinate bits are kept.
	task automatic program_aim(input logic idx, input logic [11:0] value);
		logic [31:0] noise;
		logic [31:0] rd;
		noise = $urandom;
		apb_access(1'b1, idx, {noise[31:12], value}, rd);
		apb_access(1'b0, idx, 32'd0, rd);
		if (rd !== {20'd0, value})
			flag_mismatch($sformatf("register %0d read back %0h, wrote %0h", idx, rd, value));
	endtask

	task automatic settle();
		start <= 1'b0;
		while (awaited_readings.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	task automatic move_aim(input logic [11:0] ax, input logic [11:0] ay);
		settle();
		program_aim(REG_AIM_X, ax);
		program_aim(REG_AIM_Y, ay);
		aim_x_set = ax;
		aim_y_set = ay;
	endtask

	task automatic send_item(input logic [11:0] px, input logic [11:0] py,
			input logic known, input out_item_t answer);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		sample <= '{pointer_x: px, pointer_y: py};
		pinned_known <= known;
		pinned_answer <= answer;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Most pointers land near the aim so that the speed is not always saturated,
	// some sit on an axis through it, the rest span the whole field.
	task automatic random_item();
		int kind;
		int reach;
		logic [11:0] px;
		logic [11:0] py;
		kind = $urandom_range(0, 19);
		reach = (kind == 0) ? 3 : 400;
		px = clip_coord(int'(aim_x_set) + $urandom_range(0, 2 * reach) - reach);
		py = clip_coord(int'(aim_y_set) + $urandom_range(0, 2 * reach) - reach);
		if (kind >= 11 && kind < 16) begin
			px = 12'($urandom_range(0, 4095));
			py = 12'($urandom_range(0, 4095));
		end else if (kind == 16 || kind == 17) begin
			px = aim_x_set;
		end else if (kind >= 18) begin
			py = aim_y_set;
		end
		send_item(px, py, 1'b0, '0);
	endtask

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_AIM_X)
					aim_x_seen = pwdata[11:0];
				else
					aim_y_seen = pwdata[11:0];
			end
			if (done === 1'b1) begin
				if (awaited_readings.size() == 0) begin
					flag_mismatch("result with no item outstanding");
				end else begin
					want = awaited_readings.pop_front();
					if (result.angle_deg !== want.angle_deg)
						flag_mismatch($sformatf("angle_deg %0d, expected %0d",
							result.angle_deg, want.angle_deg));
					if (result.speed !== want.speed)
						flag_mismatch($sformatf("speed %0d, expected %0d",
							result.speed, want.speed));
				end
			end else if (done !== 1'b0) begin
				flag_mismatch("done is unknown");
			end
			if (start && busy === 1'b0) begin
				if (pinned_known)
					awaited_readings.push_back(pinned_answer);
				else
					awaited_readings.push_back(predict_aim_reading(aim_x_seen, aim_y_seen,
						sample.pointer_x, sample.pointer_y));
			end
		end
	end

	initial begin : stimulus
		int row;
		int phase;
		int n;
		int guard;
		logic [11:0] ax;
		logic [11:0] ay;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the first rows run on the aim point left by reset.
		for (row = 0; row < 23; row++) begin
			if (drill[row].ax != aim_x_set || drill[row].ay != aim_y_set)
				move_aim(drill[row].ax, drill[row].ay);
			send_item(drill[row].px, drill[row].py, drill[row].known,
				'{angle_deg: drill[row].angle, speed: drill[row].speed});
		end

		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin ax = 12'd0;    ay = 12'd0;    end
				1: begin ax = 12'd4095; ay = 12'd4095; end
				2: begin ax = 12'd0;    ay = 12'd4095; end
				3: begin ax = 12'd4095; ay = 12'd0;    end
				default: begin
					ax = 12'($urandom_range(0, 4095));
					ay = 12'($urandom_range(0, 4095));
				end
			endcase
			move_aim(ax, ay);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// Let the pipeline run dry once in the middle of a phase.
				if (phase == 5 && n == PHASE_ITEMS / 2)
					settle();
				random_item();
			end
		end

		start <= 1'b0;
		for (guard = 0; guard < 1000 && awaited_readings.size() != 0; guard++)
			@(posedge clk);
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (awaited_readings.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", awaited_readings.size()));
		if (mismatches == 0)
			$display("aim_vector_angle_and_speed_top verification clean");
		else
			$display("aim_vector_angle_and_speed_top verification failed");
		$finish;
	end

endmodule
`default_nettype wire
